### rtl/bale_pkg.sv
// Package for the bounded array list engine: sizes, field widths, types and codes.
// Used by bounded_array_list_engine and its checker; depends on nothing else.
package bale_pkg;

    localparam int unsigned CAPACITY = 64;
    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    localparam int unsigned POS_W = 7;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned FPOS_W = 6;
    localparam int unsigned ECNT_W = 7;

    localparam int unsigned IN_TDATA_W = 40;
    localparam int unsigned IN_TUSER_W = 3;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 2;

    typedef logic [IDX_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [FPOS_W-1:0] fpos_t;
    typedef logic [ECNT_W-1:0] ecnt_t;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_GET    = 3'd5,
        OP_FIND   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

endpackage

### rtl/bale_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic storage block; depends on no package.
module bale_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/bounded_array_list_engine.sv
// Top level of the bounded array list engine: request decode, sequencer and result register.
// Depends on bale_pkg and bale_ram.
//
//  Channel   Dir  Signals                        Contents
//  s_axis    in   tvalid tready tdata tuser      one request: opcode, position, data_in
//  m_axis    out  tvalid tready tdata tuser      one result per request
//
// Append, set, clear, an insert at the end, the unused code and rejected requests go
// straight from idle to the result; get first reads the RAM. An insert below the count,
// remove and find (until a hit) walk the stored words, one stored word a cycle through
// the single RAM read port.
// Reset clears the count and the control state; the RAM is not cleared and needs no pass.
// A finished result waits in the output register while the next request is accepted.
module bounded_array_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: position[6:0], data_in[38:7], zero pad.
    input  logic [bale_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: opcode[2:0].
    input  logic [bale_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: data_out[31:0], found_position[37:32],
    // element_count[44:38], is_empty[45], zero pad.
    output logic [bale_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [bale_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_DRAIN,
        S_INS_FIN,
        S_REM,
        S_REM_DRAIN,
        S_GET,
        S_FIND,
        S_FIND_LAST,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    bale_pkg::cnt_t count_reg, count_next;
    bale_pkg::addr_t pos_reg, pos_next;
    bale_pkg::addr_t ptr_reg, ptr_next;
    bale_pkg::addr_t ra_reg, ra_next;
    logic rv_reg, rv_next;
    bale_pkg::word_t val_reg, val_next;
    bale_pkg::status_t res_status_reg, res_status_next;
    bale_pkg::word_t res_data_reg, res_data_next;
    bale_pkg::fpos_t res_fpos_reg, res_fpos_next;
    logic out_valid_reg, out_valid_next;
    logic [bale_pkg::OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [bale_pkg::OUT_TUSER_W-1:0] out_tuser_reg, out_tuser_next;

    logic mem_we;
    bale_pkg::addr_t mem_waddr;
    bale_pkg::word_t mem_wdata;
    logic mem_re;
    bale_pkg::addr_t mem_raddr;
    bale_pkg::word_t mem_rdata;

    bale_pkg::op_t in_op;
    bale_pkg::pos_t in_pos;
    bale_pkg::word_t in_data;
    logic [31:0] pos_w;
    logic [31:0] cnt_w;
    logic full;
    bale_pkg::cnt_t count_m1;
    logic ptr_at_end;

    assign in_op = bale_pkg::op_t'(s_axis_tuser[2:0]);
    assign in_pos = s_axis_tdata[6:0];
    assign in_data = s_axis_tdata[38:7];
    assign pos_w = 32'(in_pos);
    assign cnt_w = 32'(count_reg);
    assign full = (cnt_w >= bale_pkg::CAPACITY);
    assign count_m1 = count_reg - bale_pkg::cnt_t'(1);
    assign ptr_at_end = (bale_pkg::cnt_t'(ptr_reg) == count_m1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_tdata_reg;
    assign m_axis_tuser = out_tuser_reg;

    bale_ram #(
        .DEPTH(bale_pkg::CAPACITY),
        .WIDTH(bale_pkg::WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        ptr_next = ptr_reg;
        ra_next = ra_reg;
        rv_next = 1'b0;
        val_next = val_reg;
        res_status_next = res_status_reg;
        res_data_next = res_data_reg;
        res_fpos_next = res_fpos_reg;
        out_valid_next = out_valid_reg;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        mem_we = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = mem_rdata;
        mem_re = 1'b0;
        mem_raddr = ptr_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    val_next = in_data;
                    pos_next = bale_pkg::addr_t'(in_pos);
                    res_status_next = bale_pkg::ST_OK;
                    res_data_next = '0;
                    res_fpos_next = '0;
                    state_next = S_DONE;
                    case (in_op)
                        bale_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = bale_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_waddr = bale_pkg::addr_t'(count_reg);
                                mem_wdata = in_data;
                                count_next = count_reg + bale_pkg::cnt_t'(1);
                            end
                        end
                        bale_pkg::OP_INSERT:
                        begin
                            if (pos_w > cnt_w)
                            begin
                                res_status_next = bale_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                res_status_next = bale_pkg::ST_FULL;
                            end
                            else if (pos_w == cnt_w)
                            begin
                                mem_we = 1'b1;
                                mem_waddr = bale_pkg::addr_t'(count_reg);
                                mem_wdata = in_data;
                                count_next = count_reg + bale_pkg::cnt_t'(1);
                            end
                            else
                            begin
                                ptr_next = bale_pkg::addr_t'(count_m1);
                                state_next = S_INS;
                            end
                        end
                        bale_pkg::OP_SET:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                res_status_next = bale_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_waddr = bale_pkg::addr_t'(in_pos);
                                mem_wdata = in_data;
                            end
                        end
                        bale_pkg::OP_REMOVE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                res_status_next = bale_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ptr_next = bale_pkg::addr_t'(in_pos);
                                state_next = S_REM;
                            end
                        end
                        bale_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        bale_pkg::OP_GET:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                res_status_next = bale_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_raddr = bale_pkg::addr_t'(in_pos);
                                state_next = S_GET;
                            end
                        end
                        bale_pkg::OP_FIND:
                        begin
                            res_status_next = bale_pkg::ST_NOTFOUND;
                            if (count_reg != '0)
                            begin
                                ptr_next = '0;
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            res_status_next = bale_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_INS, S_INS_DRAIN:
            begin
                if (rv_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = ra_reg + bale_pkg::addr_t'(1);
                    mem_wdata = mem_rdata;
                end
                if (state_reg == S_INS)
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg;
                    rv_next = 1'b1;
                    ra_next = ptr_reg;
                    if (ptr_reg == pos_reg)
                    begin
                        state_next = S_INS_DRAIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - bale_pkg::addr_t'(1);
                    end
                end
                else
                begin
                    state_next = S_INS_FIN;
                end
            end
            S_INS_FIN:
            begin
                mem_we = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = val_reg;
                count_next = count_reg + bale_pkg::cnt_t'(1);
                state_next = S_DONE;
            end
            S_REM, S_REM_DRAIN:
            begin
                if (rv_reg)
                begin
                    if (ra_reg == pos_reg)
                    begin
                        res_data_next = mem_rdata;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_waddr = ra_reg - bale_pkg::addr_t'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                if (state_reg == S_REM)
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg;
                    rv_next = 1'b1;
                    ra_next = ptr_reg;
                    if (ptr_at_end)
                    begin
                        state_next = S_REM_DRAIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + bale_pkg::addr_t'(1);
                    end
                end
                else
                begin
                    count_next = count_m1;
                    state_next = S_DONE;
                end
            end
            S_GET:
            begin
                res_data_next = mem_rdata;
                state_next = S_DONE;
            end
            S_FIND:
            begin
                if (rv_reg && (mem_rdata == val_reg))
                begin
                    res_status_next = bale_pkg::ST_OK;
                    res_fpos_next = bale_pkg::fpos_t'(ra_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg;
                    rv_next = 1'b1;
                    ra_next = ptr_reg;
                    if (ptr_at_end)
                    begin
                        state_next = S_FIND_LAST;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + bale_pkg::addr_t'(1);
                    end
                end
            end
            S_FIND_LAST:
            begin
                if (mem_rdata == val_reg)
                begin
                    res_status_next = bale_pkg::ST_OK;
                    res_fpos_next = bale_pkg::fpos_t'(ra_reg);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_tuser_next = res_status_reg;
                    out_tdata_next = {2'b00,
                                      (count_reg == '0),
                                      bale_pkg::ecnt_t'(count_reg),
                                      res_fpos_reg,
                                      res_data_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        ra_reg <= ra_next;
        val_reg <= val_next;
        res_status_reg <= res_status_next;
        res_data_reg <= res_data_next;
        res_fpos_reg <= res_fpos_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

endmodule

### rtl/bale_chk.sv
// Port-level checker for bounded_array_list_engine, attached by the bind at the end.
// Depends on bale_pkg.
module bale_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [bale_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input logic [bale_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [bale_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [bale_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("Stalled result changed or was dropped.");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[45] == (m_axis_tdata[44:38] == '0)))
        else $error("Empty flag disagrees with the element count.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[44:38]) <= bale_pkg::CAPACITY))
        else $error("Element count exceeds the capacity.");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != bale_pkg::ST_OK)
            |-> (m_axis_tdata[31:0] == '0) && (m_axis_tdata[37:32] == '0))
        else $error("Failed request returned data or a found position.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == bale_pkg::ST_FULL)
            |-> (32'(m_axis_tdata[44:38]) == (bale_pkg::CAPACITY % 128)))
        else $error("Full status reported below capacity.");

endmodule

bind bounded_array_list_engine bale_chk u_bale_chk (.*);

### dv/bounded_array_list_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded array list engine: watches both stream channels, predicts each reply
// from its own copy of the list and compares it field by field. Depends on bale_pkg.
module bounded_array_list_checker
    import bale_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output int                     mismatches,
    output int                     replies_checked,
    output int                     replies_due,
    output int                     list_len
);

    typedef struct {
        status_t status;
        word_t   data;
        fpos_t   fpos;
        ecnt_t   ecnt;
        logic    empty;
    } list_reply_t;

    word_t       shadow_words [CAPACITY];
    int unsigned shadow_len;
    list_reply_t replies_owed [$];

    function automatic list_reply_t apply_list_op(logic [2:0] op, pos_t pos, word_t value);
        list_reply_t r;
        int unsigned i;
        r.status = ST_OK;
        r.data   = '0;
        r.fpos   = '0;
        case (op)
            OP_APPEND:
                if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = value;
                    shadow_len++;
                end
            OP_INSERT:
                if (pos > shadow_len)
                    r.status = ST_RANGE;
                else if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = value;
                    shadow_len++;
                end
            OP_SET:
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                    shadow_words[pos] = value;
            OP_REMOVE:
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.data = shadow_words[pos];
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            OP_CLEAR:
                shadow_len = 0;
            OP_GET:
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                    r.data = shadow_words[pos];
            OP_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < shadow_len; i++)
                begin
                    if (shadow_words[i] == value)
                    begin
                        r.status = ST_OK;
                        r.fpos   = fpos_t'(i);
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        r.ecnt  = ecnt_t'(shadow_len);
        r.empty = (shadow_len == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch on reply %0d: got 0x%0h, expected 0x%0h",
                 $time, field, replies_checked, got, want);
        mismatches++;
    endtask

    task automatic check_list_reply();
        list_reply_t want;
        if (replies_owed.size() == 0)
        begin
            report_mismatch("unrequested reply", m_axis_tdata[31:0], '0);
            return;
        end
        want = replies_owed.pop_front();
        if (status_t'(m_axis_tuser) !== want.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.data)
            report_mismatch("data_out", m_axis_tdata[31:0], want.data);
        if (m_axis_tdata[37:32] !== want.fpos)
            report_mismatch("found_position", 32'(m_axis_tdata[37:32]), 32'(want.fpos));
        if (m_axis_tdata[44:38] !== want.ecnt)
            report_mismatch("element_count", 32'(m_axis_tdata[44:38]), 32'(want.ecnt));
        if (m_axis_tdata[45] !== want.empty)
            report_mismatch("is_empty", 32'(m_axis_tdata[45]), 32'(want.empty));
        replies_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            replies_owed.delete();
            replies_due <= 0;
            list_len    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_list_reply();
            if (s_axis_tvalid && s_axis_tready)
                replies_owed.push_back(apply_list_op(s_axis_tuser[2:0], s_axis_tdata[6:0],
                                                     s_axis_tdata[38:7]));
            replies_due <= replies_owed.size();
            list_len    <= shadow_len;
        end
    end

endmodule

### dv/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bounded array list engine: clock, reset, request and reply traffic
// with random idling, and the verdict. Depends on bale_pkg and bounded_array_list_checker.
module bounded_array_list_engine_tb;
    import bale_pkg::*;

    localparam int         CLK_HALF       = 4;
    localparam int         CYCLE_LIMIT    = 1_000_000;
    localparam int         REQUEST_TARGET = 1650;
    localparam logic [2:0] OP_NOP         = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} op_mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int mismatches;
    int replies_checked;
    int replies_due;
    int list_len;

    int tx_idle_max = 9;
    int rx_idle_max = 9;
    int requests_sent = 0;
    int op_sent [8];
    int cycle_count = 0;

    bounded_array_list_engine i_dut (.*);

    bounded_array_list_checker i_checker (.*);

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : reply_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(input logic [2:0] op, input pos_t pos, input word_t value);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, pos};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
        op_sent[op]++;
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (replies_due != 0);
    endtask

    function automatic logic [2:0] pick_op(op_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                if (r < 50) return OP_APPEND;
                else if (r < 85) return OP_INSERT;
                else if (r < 90) return OP_GET;
                else if (r < 95) return OP_FIND;
                else return OP_SET;
            MIX_DRAIN:
                if (r < 60) return OP_REMOVE;
                else if (r < 70) return OP_GET;
                else if (r < 80) return OP_FIND;
                else if (r < 88) return OP_SET;
                else if (r < 93) return OP_INSERT;
                else if (r < 97) return OP_APPEND;
                else if (r < 99) return OP_CLEAR;
                else return OP_NOP;
            default:
                if (r < 20) return OP_APPEND;
                else if (r < 35) return OP_INSERT;
                else if (r < 47) return OP_SET;
                else if (r < 62) return OP_REMOVE;
                else if (r < 64) return OP_CLEAR;
                else if (r < 77) return OP_GET;
                else if (r < 99) return OP_FIND;
                else return OP_NOP;
        endcase
    endfunction

    function automatic pos_t pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return pos_t'($urandom_range(0, list_len));
        else if (r < 90) return pos_t'($urandom_range(0, 127));
        else if (r < 95) return pos_t'(list_len);
        else if (r < 97) return pos_t'(CAPACITY - 1);
        else return pos_t'(127);
    endfunction

    // A small pool of repeated values makes find hits and duplicate entries common.
    function automatic word_t pick_value();
        if ($urandom_range(0, 99) >= 45)
            return word_t'($urandom());
        case ($urandom_range(0, 7))
            0: return word_t'(32'h0000_0000);
            1: return word_t'(32'hFFFF_FFFF);
            2: return word_t'(32'h0000_0001);
            3: return word_t'(32'h0000_0007);
            4: return word_t'(32'h7FFF_FFFF);
            5: return word_t'(32'h8000_0000);
            6: return word_t'(32'h0000_002A);
            default: return word_t'(32'h0000_0064);
        endcase
    endfunction

    initial
    begin : request_source
        op_mix_t mix;
        int      phase_len;
        int      phase_no;
        foreach (op_sent[k])
            op_sent[k] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads on an empty list, then a few words at the extremes.
        send_request(OP_GET, 0, 0);
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_FIND, 0, 0);
        send_request(OP_APPEND, 0, word_t'(32'h7FFF_FFFF));
        send_request(OP_APPEND, 127, word_t'(32'h8000_0000));
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, 3, word_t'(32'hFFFF_FFFF));
        send_request(OP_INSERT, 5, 9);
        send_request(OP_INSERT, 127, 9);
        send_request(OP_GET, 1, 0);
        send_request(OP_GET, 4, 0);
        send_request(OP_GET, 127, 0);
        send_request(OP_SET, 2, 55);
        send_request(OP_SET, 4, 56);
        send_request(OP_SET, 127, 57);
        send_request(OP_FIND, 0, word_t'(32'hFFFF_FFFF));
        send_request(OP_FIND, 0, 55);
        send_request(OP_FIND, 0, word_t'(32'h8000_0000));
        send_request(OP_REMOVE, 1, 0);
        send_request(OP_REMOVE, 64, 0);
        send_request(OP_REMOVE, 127, 0);
        send_request(OP_NOP, 127, word_t'(32'hFFFF_FFFF));
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_GET, 0, 0);
        send_request(OP_FIND, 0, 0);
        wait_for_replies();

        // The first phase fills the list past capacity so full rejections are seen early.
        phase_no = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            mix = (phase_no == 0) ? MIX_FILL : op_mix_t'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                1:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = 9;
                end
                2:
                begin
                    tx_idle_max = 9;
                    rx_idle_max = 0;
                end
                default:
                begin
                    tx_idle_max = 9;
                    rx_idle_max = 9;
                end
            endcase
            phase_len = (phase_no == 0) ? 150 : $urandom_range(40, 120);
            repeat (phase_len)
                send_request(pick_op(mix), pick_position(), pick_value());
            if ($urandom_range(0, 3) == 0)
                wait_for_replies();
            phase_no++;
        end

        wait_for_replies();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests: %0d append, %0d insert, %0d set, %0d remove, %0d clear,",
                 requests_sent, op_sent[OP_APPEND], op_sent[OP_INSERT], op_sent[OP_SET],
                 op_sent[OP_REMOVE], op_sent[OP_CLEAR]);
        $display("%0d get, %0d find, %0d unused code; %0d replies checked in %0d cycles.",
                 op_sent[OP_GET], op_sent[OP_FIND], op_sent[OP_NOP], replies_checked,
                 cycle_count);
        if (mismatches == 0 && replies_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
